// ----- rtl/core/bdqs_pkg.sv -----
// Shared constants, command codes and types for the bounded deque with search.
`default_nettype none
package bdqs_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = 5;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VAL_W = 32;
    localparam int CMD_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_BACK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VALUE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef logic signed [VAL_W-1:0] value_t;

    typedef struct packed {
        logic             en;
        logic [CMD_W-1:0] cmd;
        logic             full;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/bdqs_cell.sv -----
// One storage cell of the deque chain: holds one entry and shifts with its neighbors.
`default_nettype none
module bdqs_cell (
    input  wire logic               clk,
    input  wire bdqs_pkg::cell_ctrl_t ctrl,
    input  wire bdqs_pkg::value_t   operand,
    input  wire logic               occ,
    input  wire logic               left_occ,
    input  wire bdqs_pkg::value_t   left_value,
    input  wire bdqs_pkg::value_t   right_value,
    input  wire logic               match_in,
    output bdqs_pkg::value_t        value,
    output bdqs_pkg::value_t        value_next,
    output logic                    match_out
);

    bdqs_pkg::value_t value_reg;

    assign value = value_reg;
    assign match_out = match_in | (occ && (value_reg == operand));

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.cmd)
            bdqs_pkg::CMD_ADD_FRONT:
            begin
                if (!ctrl.full)
                begin
                    value_next = left_value;
                end
            end
            bdqs_pkg::CMD_ADD_BACK:
            begin
                if (!occ && left_occ)
                begin
                    value_next = operand;
                end
            end
            bdqs_pkg::CMD_REMOVE_FRONT:
            begin
                value_next = right_value;
            end
            bdqs_pkg::CMD_REMOVE_VALUE:
            begin
                if (match_out)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            value_reg <= value_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search: cell chain, count and result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------------
//  input    | in_valid / in_ready   | cmd, operand_value
//  output   | out_valid / out_ready | front_value, back_value, entry_count, is_empty,
//           |                       | found, status
//
// Every item completes on acceptance; its result shows in the output register the
// cycle after acceptance, and a new item is taken each cycle while the output drains.
// Search and delete ripple a match flag combinationally through the row of cells.
// Reset clears the count and the output valid; entry values need no clearing.
// A stalled output holds its result and blocks input only while it stays full.
`default_nettype none
module bounded_deque_with_search (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [bdqs_pkg::CMD_W-1:0]          cmd,
    input  wire logic signed [bdqs_pkg::VAL_W-1:0]   operand_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [bdqs_pkg::VAL_W-1:0]        front_value,
    output logic signed [bdqs_pkg::VAL_W-1:0]        back_value,
    output logic [bdqs_pkg::CNT_W-1:0]               entry_count,
    output logic                                     is_empty,
    output logic                                     found,
    output logic [bdqs_pkg::STATUS_W-1:0]            status
);

    logic                            accept;
    logic [bdqs_pkg::CNT_W-1:0]      count_reg;
    logic [bdqs_pkg::CNT_W-1:0]      count_next;
    logic                            full;
    logic                            empty;
    logic                            any_match;
    logic [bdqs_pkg::STATUS_W-1:0]   status_next;
    logic                            found_next;
    logic [bdqs_pkg::IDX_W-1:0]      back_idx;
    bdqs_pkg::cell_ctrl_t            ctrl;
    bdqs_pkg::value_t                front_next;
    bdqs_pkg::value_t                back_next;

    logic                            occ        [bdqs_pkg::DEPTH];
    logic                            match      [bdqs_pkg::DEPTH];
    bdqs_pkg::value_t                cell_value [bdqs_pkg::DEPTH];
    bdqs_pkg::value_t                cell_next  [bdqs_pkg::DEPTH];

    logic                            out_valid_reg;
    bdqs_pkg::value_t                front_reg;
    bdqs_pkg::value_t                back_reg;
    logic [bdqs_pkg::CNT_W-1:0]      entry_count_reg;
    logic                            found_reg;
    logic [bdqs_pkg::STATUS_W-1:0]   status_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == bdqs_pkg::CNT_W'(bdqs_pkg::DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.en   = accept;
    assign ctrl.cmd  = cmd;
    assign ctrl.full = full;

    for (genvar i = 0; i < bdqs_pkg::DEPTH; i++)
    begin : g_cell
        logic             left_occ;
        logic             match_in;
        bdqs_pkg::value_t left_value;
        bdqs_pkg::value_t right_value;

        assign occ[i] = (count_reg > bdqs_pkg::CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_occ   = 1'b1;
            assign left_value = operand_value;
            assign match_in   = 1'b0;
        end
        else
        begin : g_body
            assign left_occ   = occ[i-1];
            assign left_value = cell_value[i-1];
            assign match_in   = match[i-1];
        end

        if (i == bdqs_pkg::DEPTH - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        bdqs_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .operand     (operand_value),
            .occ         (occ[i]),
            .left_occ    (left_occ),
            .left_value  (left_value),
            .right_value (right_value),
            .match_in    (match_in),
            .value       (cell_value[i]),
            .value_next  (cell_next[i]),
            .match_out   (match[i])
        );
    end

    assign any_match = match[bdqs_pkg::DEPTH-1];

    always_comb
    begin
        count_next  = count_reg;
        status_next = bdqs_pkg::STATUS_OK;
        found_next  = 1'b0;
        unique case (cmd)
            bdqs_pkg::CMD_ADD_FRONT,
            bdqs_pkg::CMD_ADD_BACK:
            begin
                if (full)
                begin
                    status_next = bdqs_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + bdqs_pkg::CNT_W'(1);
                end
            end
            bdqs_pkg::CMD_REMOVE_FRONT,
            bdqs_pkg::CMD_REMOVE_BACK:
            begin
                if (empty)
                begin
                    status_next = bdqs_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - bdqs_pkg::CNT_W'(1);
                end
            end
            bdqs_pkg::CMD_CONTAINS:
            begin
                found_next = any_match;
            end
            bdqs_pkg::CMD_REMOVE_VALUE:
            begin
                if (empty)
                begin
                    status_next = bdqs_pkg::STATUS_EMPTY;
                end
                else if (any_match)
                begin
                    found_next = 1'b1;
                    count_next = count_reg - bdqs_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign back_idx   = bdqs_pkg::IDX_W'(count_next - bdqs_pkg::CNT_W'(1));
    assign front_next = (count_next == '0) ? '0 : cell_next[0];
    assign back_next  = (count_next == '0) ? '0 : cell_next[back_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg       <= front_next;
            back_reg        <= back_next;
            entry_count_reg <= count_next;
            found_reg       <= found_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = (entry_count_reg == '0);
    assign found       = found_reg;
    assign status      = status_reg;

endmodule
`default_nettype wire
